/* hw/rtl/imc_pkg.sv */
// Shared types and constants for the three-level masked interrupt controller.
// No dependencies; the state, level and top-level files take names from here by scope.
`default_nettype none

package imc_pkg;

  // Number of mask words: three levels times three classes
  localparam int unsigned MASK_COUNT = 9;

  // Read-back composition of the normal status word
  localparam logic [31:0] NRM_LOW_BITS = 32'h3FFF_FFFF;
  localparam logic [31:0] EXT_ANY_BIT  = 32'h4000_0000;
  localparam logic [31:0] ERR_ANY_BIT  = 32'h8000_0000;

  // Request function codes
  typedef enum logic [2:0] {
    FUNC_RAISE        = 3'd0,
    FUNC_RAISE_BOTH   = 3'd1,
    FUNC_CANCEL       = 3'd2,
    FUNC_READ_NORMAL  = 3'd3,
    FUNC_CLEAR_NORMAL = 3'd4,
    FUNC_CLEAR_ERROR  = 3'd5,
    FUNC_WRITE_MASK   = 3'd6,
    FUNC_WRITE_EXT    = 3'd7
  } func_t;

  // Source classes, taken from source_id bits 9:8
  typedef enum logic [1:0] {
    CLS_NORMAL   = 2'd0,
    CLS_EXTERNAL = 2'd1,
    CLS_ERROR    = 2'd2,
    CLS_NONE     = 2'd3
  } cls_t;

  // One registered request
  typedef struct packed {
    func_t       func;
    logic [9:0]  source_id;
    logic        bank_select;
    logic [3:0]  mask_index;
    logic [31:0] write_data;
  } item_t;

  // The four status words
  typedef struct packed {
    logic [31:0] normal;
    logic [31:0] normal_b;
    logic [31:0] external;
    logic [31:0] error;
  } status_t;

  // Mask words, index = level*3 + class
  typedef logic [31:0] mask_arr_t [MASK_COUNT];

  // Level request lines
  typedef struct packed {
    logic level6;
    logic level4;
    logic level2;
  } levels_t;

endpackage

`default_nettype wire

/* hw/rtl/imc_if.sv */
// Request and response channel interfaces for the interrupt controller.
// Depends on nothing but plain logic types.
`default_nettype none

interface imc_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  func;
  logic [9:0]  source_id;
  logic        bank_select;
  logic [3:0]  mask_index;
  logic [31:0] write_data;

  modport source (output valid, func, source_id, bank_select, mask_index, write_data,
                  input ready);
  modport sink   (input valid, func, source_id, bank_select, mask_index, write_data,
                  output ready);
endinterface

interface imc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        level6_pending;
  logic        level4_pending;
  logic        level2_pending;

  modport source (output valid, read_data, level6_pending, level4_pending, level2_pending,
                  input ready);
  modport sink   (input valid, read_data, level6_pending, level4_pending, level2_pending,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/imc_state.sv */
// Status and mask registers with their per-request update and status read-back.
// Depends on imc_pkg.
`default_nettype none

module imc_state (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               en,
  input  wire imc_pkg::item_t     item,
  input  wire logic               dual_bank_mode,
  output imc_pkg::status_t        status_next,
  output imc_pkg::mask_arr_t      masks_next,
  output logic [31:0]             read_data
);

  imc_pkg::status_t   status;
  imc_pkg::mask_arr_t masks;

  logic          second;
  imc_pkg::cls_t cls;
  logic [31:0]   bitv;

  // Decode the request fields
  assign second = dual_bank_mode & item.bank_select;
  assign cls    = imc_pkg::cls_t'(item.source_id[9:8]);
  assign bitv   = 32'd1 << item.source_id[4:0];

  // Compose the normal status read-back from the current state
  always_comb begin
    read_data = 32'd0;
    if (item.func == imc_pkg::FUNC_READ_NORMAL) begin
      read_data = (second ? status.normal_b : status.normal) & imc_pkg::NRM_LOW_BITS;
      if (status.external != 32'd0) read_data = read_data | imc_pkg::EXT_ANY_BIT;
      if (status.error != 32'd0)    read_data = read_data | imc_pkg::ERR_ANY_BIT;
    end
  end

  // Work out the state after the request
  always_comb begin
    status_next = status;
    masks_next  = masks;
    if (en) begin
      unique case (item.func)
        imc_pkg::FUNC_RAISE, imc_pkg::FUNC_RAISE_BOTH: begin
          case (cls)
            imc_pkg::CLS_NORMAL: begin
              status_next.normal = status.normal | bitv;
              if (item.func == imc_pkg::FUNC_RAISE_BOTH)
                status_next.normal_b = status.normal_b | bitv;
            end
            imc_pkg::CLS_EXTERNAL: status_next.external = status.external | bitv;
            imc_pkg::CLS_ERROR:    status_next.error    = status.error | bitv;
            default: ;
          endcase
        end
        imc_pkg::FUNC_CANCEL: begin
          case (cls)
            imc_pkg::CLS_NORMAL:   status_next.normal   = status.normal & ~bitv;
            imc_pkg::CLS_EXTERNAL: status_next.external = status.external & ~bitv;
            imc_pkg::CLS_ERROR:    status_next.error    = status.error & ~bitv;
            default: ;
          endcase
        end
        imc_pkg::FUNC_CLEAR_NORMAL: begin
          if (second) status_next.normal_b = status.normal_b & ~item.write_data;
          else        status_next.normal   = status.normal & ~item.write_data;
        end
        imc_pkg::FUNC_CLEAR_ERROR: begin
          status_next.error = status.error & ~item.write_data;
        end
        imc_pkg::FUNC_WRITE_MASK: begin
          // drop writes from the second bank and beyond the last mask word
          if (!second && item.mask_index < 4'(imc_pkg::MASK_COUNT))
            masks_next[item.mask_index] = item.write_data;
        end
        default: ;
      endcase
    end
  end

  // Hold the state
  always_ff @(posedge clk) begin
    if (rst) begin
      status <= '0;
      for (int i = 0; i < int'(imc_pkg::MASK_COUNT); i++) masks[i] <= 32'd0;
    end else begin
      status <= status_next;
      masks  <= masks_next;
    end
  end

`ifndef SYNTH
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (status == '0 && masks[0] == 32'd0 && masks[8] == 32'd0))
    else $error("state not cleared by reset");

  a_cancel_keeps_bank_b: assert property (@(posedge clk) disable iff (rst)
    (en && item.func == imc_pkg::FUNC_CANCEL) |=> $stable(status.normal_b))
    else $error("cancel touched second normal bank");

  a_read_keeps_status: assert property (@(posedge clk) disable iff (rst)
    (en && item.func == imc_pkg::FUNC_READ_NORMAL) |=> $stable(status))
    else $error("status read changed status");

  a_idle_keeps_status: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(status))
    else $error("status changed with no request applied");
`endif

endmodule

`default_nettype wire

/* hw/rtl/imc_levels.sv */
// Level request evaluation: OR over classes of status AND mask, per level.
// Depends on imc_pkg.
`default_nettype none

module imc_levels (
  input  wire imc_pkg::status_t   status,
  input  wire imc_pkg::mask_arr_t masks,
  output imc_pkg::levels_t        levels
);

  logic [2:0] hit;

  // Test each level against its three class masks; bank b uses the normal mask
  always_comb begin
    for (int lvl = 0; lvl < 3; lvl++) begin
      hit[lvl] = |(((status.normal | status.normal_b) & masks[lvl * 3])
                   | (status.external & masks[lvl * 3 + 1])
                   | (status.error & masks[lvl * 3 + 2]));
    end
  end

  assign levels.level2 = hit[0];
  assign levels.level4 = hit[1];
  assign levels.level6 = hit[2];

endmodule

`default_nettype wire

/* hw/rtl/three_level_masked_interrupt_controller_core.sv */
// Top level of the three-level masked interrupt controller.
// Depends on imc_pkg, imc_if, imc_state and imc_levels.
//
//   channel  | dir | payload
//   ---------+-----+--------------------------------------------------------
//   req      | in  | func, source_id, bank_select, mask_index, write_data
//   rsp      | out | read_data, level6_pending, level4_pending, level2_pending
//   cfg      | in  | cfg_write_en, cfg_write_data (dual_bank_mode)
//
// One request per cycle while the response side is not stalled: an input register,
// then the state update and level evaluation into the response register.
// The input register refills in the same cycle it drains, so req.ready drops
// only while a response waits and the input register is full.
// Reset (synchronous) clears all status and mask words and dual_bank_mode.
`default_nettype none

module three_level_masked_interrupt_controller_core (
  input  wire logic  clk,
  input  wire logic  rst,
  imc_req_if.sink    req,
  imc_rsp_if.source  rsp,
  input  wire logic  cfg_write_en,
  input  wire logic  cfg_write_data
);

  logic               dual_bank_mode;
  logic               s1_valid;
  imc_pkg::item_t     s1_item;
  logic               advance;
  logic               take;
  imc_pkg::status_t   status_next;
  imc_pkg::mask_arr_t masks_next;
  logic [31:0]        read_data_next;
  imc_pkg::levels_t   levels_next;

  // Handshake: move the held request on when the response register is free
  assign advance   = s1_valid & (~rsp.valid | rsp.ready);
  assign req.ready = ~s1_valid | advance;
  assign take      = req.valid & req.ready;

  // Hold the mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      dual_bank_mode <= 1'b0;
    end else if (cfg_write_en) begin
      dual_bank_mode <= cfg_write_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_item.func        <= imc_pkg::func_t'(req.func);
      s1_item.source_id   <= req.source_id;
      s1_item.bank_select <= req.bank_select;
      s1_item.mask_index  <= req.mask_index;
      s1_item.write_data  <= req.write_data;
    end
  end

  imc_state u_state (
    .clk            (clk),
    .rst            (rst),
    .en             (advance),
    .item           (s1_item),
    .dual_bank_mode (dual_bank_mode),
    .status_next    (status_next),
    .masks_next     (masks_next),
    .read_data      (read_data_next)
  );

  imc_levels u_levels (
    .status (status_next),
    .masks  (masks_next),
    .levels (levels_next)
  );

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (advance) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp.read_data      <= read_data_next;
      rsp.level6_pending <= levels_next.level6;
      rsp.level4_pending <= levels_next.level4;
      rsp.level2_pending <= levels_next.level2;
    end
  end

endmodule

`default_nettype wire
